// ===== hdl/mvab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvab_pkg
// Shared types and constants of the mesh vertex adjacency builder: field
// widths, request kinds, and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mvab_pkg;

  // Field widths.
  localparam int VERTEX_W    = 12;
  localparam int ENTRY_W     = 13;
  localparam int COUNT_W     = 13;
  localparam int KIND_W      = 2;
  localparam int SHOWN_SLOTS = 6;

  // Default sizes of the neighbor store.
  localparam int MAX_VERTICES_DEF     = 4096;
  localparam int SLOTS_PER_VERTEX_DEF = 6;

  // Vertex count after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_FACE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    logic       wr_en;
    logic       clr_en;
    logic       out_load;
    logic [1:0] corner;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bad;
    logic              clr_last;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/mvab_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvab_datapath
// Holds the request register, the vertex count register, the neighbor row
// memory, the row merge logic, the clear counter and the result register.
// ----------------------------------------------------------------------------
module mvab_datapath #(
  parameter int MAX_VERTICES     = mvab_pkg::MAX_VERTICES_DEF,
  parameter int SLOTS_PER_VERTEX = mvab_pkg::SLOTS_PER_VERTEX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mvab_pkg::cmd_t                     cmd,
  output mvab_pkg::sts_t                          sts,
  input  wire logic [mvab_pkg::KIND_W-1:0]        kind,
  input  wire logic [mvab_pkg::VERTEX_W-1:0]      vertex_a,
  input  wire logic [mvab_pkg::VERTEX_W-1:0]      vertex_b,
  input  wire logic [mvab_pkg::VERTEX_W-1:0]      vertex_c,
  input  wire logic                               cfg_valid,
  input  wire logic [mvab_pkg::COUNT_W-1:0]       cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [mvab_pkg::ENTRY_W-1:0]     neighbor_0,
  output logic signed [mvab_pkg::ENTRY_W-1:0]     neighbor_1,
  output logic signed [mvab_pkg::ENTRY_W-1:0]     neighbor_2,
  output logic signed [mvab_pkg::ENTRY_W-1:0]     neighbor_3,
  output logic signed [mvab_pkg::ENTRY_W-1:0]     neighbor_4,
  output logic signed [mvab_pkg::ENTRY_W-1:0]     neighbor_5,
  output logic                                    overflow,
  output logic                                    bad_index
);

  localparam int EW = mvab_pkg::ENTRY_W;
  localparam int VW = mvab_pkg::VERTEX_W;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RW = SLOTS_PER_VERTEX * EW;
  localparam int FW = $clog2(SLOTS_PER_VERTEX + 1);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_VERTICES - 1);

  // Row address of a vertex index that has already passed the limit check.
  function automatic logic [AW-1:0] row_addr(input logic [VW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[AW-1:0];
  endfunction

  // An index is rejected at or above the vertex count or the store depth.
  function automatic logic idx_bad(input logic [VW-1:0] v,
                                   input logic [mvab_pkg::COUNT_W-1:0] cnt);
    return ({1'b0, v} >= cnt) || (32'(v) >= 32'(MAX_VERTICES));
  endfunction

  logic [mvab_pkg::KIND_W-1:0]  item_kind;
  logic [VW-1:0]                item_a;
  logic [VW-1:0]                item_b;
  logic [VW-1:0]                item_c;
  logic [mvab_pkg::COUNT_W-1:0] vertex_count;
  logic                         ovf;
  logic [AW-1:0]                clr_cnt;
  logic [RW-1:0]                mem [MAX_VERTICES];
  logic [RW-1:0]                rd_data;
  logic [RW-1:0]                new_row;
  logic                         dropped;
  logic [VW-1:0]                cur_v;
  logic [VW-1:0]                cur_p;
  logic [VW-1:0]                cur_q;
  logic                         item_bad;
  logic [EW-1:0]                shown [mvab_pkg::SHOWN_SLOTS];

  // Request register, loaded when an item is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= kind;
      item_a    <= vertex_a;
      item_b    <= vertex_b;
      item_c    <= vertex_c;
    end
  end

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= mvab_pkg::COUNT_RESET;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // Index check of the held request.
  always_comb begin
    case (item_kind)
      mvab_pkg::KIND_FACE: item_bad = idx_bad(item_a, vertex_count) ||
                                      idx_bad(item_b, vertex_count) ||
                                      idx_bad(item_c, vertex_count);
      mvab_pkg::KIND_READ: item_bad = idx_bad(item_a, vertex_count);
      default:             item_bad = 1'b0;
    endcase
  end

  // Corner rotation: the row of v receives the next corner, then the one after.
  always_comb begin
    case (cmd.corner)
      2'd1:    begin cur_v = item_b; cur_p = item_c; cur_q = item_a; end
      2'd2:    begin cur_v = item_c; cur_p = item_a; cur_q = item_b; end
      default: begin cur_v = item_a; cur_p = item_b; cur_q = item_c; end
    endcase
  end

  // Clear counter sweeps every row once and wraps to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= (clr_cnt == LAST_ROW) ? '0 : clr_cnt + AW'(1);
    end
  end

  // Neighbor row memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[row_addr(cur_v)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.wr_en) begin
      mem[row_addr(cur_v)] <= new_row;
    end
  end

  // Row merge: find the first empty slot, then append the missing neighbors.
  always_comb begin
    logic [EW-1:0] tp;
    logic [EW-1:0] tq;
    logic [FW-1:0] fill;
    logic [FW-1:0] fill_q;
    logic          found;
    logic          has_p;
    logic          has_q;
    logic          need_p;
    logic          need_q;
    logic          put_p;
    logic          put_q;
    tp     = {1'b0, cur_p} + EW'(1);
    tq     = {1'b0, cur_q} + EW'(1);
    fill   = FW'(SLOTS_PER_VERTEX);
    found  = 1'b0;
    has_p  = 1'b0;
    has_q  = 1'b0;
    for (int k = 0; k < SLOTS_PER_VERTEX; k++) begin
      if (!found && rd_data[k*EW +: EW] == '0) begin
        fill  = FW'(k);
        found = 1'b1;
      end
    end
    for (int k = 0; k < SLOTS_PER_VERTEX; k++) begin
      if (FW'(k) < fill && rd_data[k*EW +: EW] == tp) has_p = 1'b1;
      if (FW'(k) < fill && rd_data[k*EW +: EW] == tq) has_q = 1'b1;
    end
    need_p  = !has_p;
    need_q  = !has_q && (tq != tp);
    put_p   = need_p && (fill < FW'(SLOTS_PER_VERTEX));
    fill_q  = fill + {{(FW-1){1'b0}}, put_p};
    put_q   = need_q && (fill_q < FW'(SLOTS_PER_VERTEX));
    dropped = (need_p && !put_p) || (need_q && !put_q);
    new_row = rd_data;
    for (int k = 0; k < SLOTS_PER_VERTEX; k++) begin
      if (put_p && FW'(k) == fill)   new_row[k*EW +: EW] = tp;
      if (put_q && FW'(k) == fill_q) new_row[k*EW +: EW] = tq;
    end
  end

  // Overflow flag collects drops over the three corners of a face.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ovf <= 1'b0;
    end else if (cmd.wr_en && dropped) begin
      ovf <= 1'b1;
    end
  end

  // Stored entries hold neighbor plus one; slots past the row show as empty.
  genvar g;
  generate
    for (g = 0; g < mvab_pkg::SHOWN_SLOTS; g++) begin : g_shown
      if (g < SLOTS_PER_VERTEX) begin : g_row
        assign shown[g] = rd_data[g*EW +: EW] - EW'(1);
      end else begin : g_pad
        assign shown[g] = '1;
      end
    end
  endgenerate

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (item_kind == mvab_pkg::KIND_READ && !item_bad) begin
        neighbor_0 <= shown[0];
        neighbor_1 <= shown[1];
        neighbor_2 <= shown[2];
        neighbor_3 <= shown[3];
        neighbor_4 <= shown[4];
        neighbor_5 <= shown[5];
      end else begin
        neighbor_0 <= '1;
        neighbor_1 <= '1;
        neighbor_2 <= '1;
        neighbor_3 <= '1;
        neighbor_4 <= '1;
        neighbor_5 <= '1;
      end
      overflow  <= (item_kind == mvab_pkg::KIND_FACE) && ovf;
      bad_index <= item_bad;
    end
  end

  // Status to the controller.
  assign sts.kind     = item_kind;
  assign sts.bad      = item_bad;
  assign sts.clr_last = (clr_cnt == LAST_ROW);
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== hdl/mvab_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvab_ctrl
// Controller state machine: accepts requests, steps the datapath through the
// read and write of each corner row, runs the clearing sweep and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module mvab_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mvab_pkg::sts_t sts,
  output mvab_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_READ     = 3'd2;
  localparam logic [2:0] ST_WRITE    = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;
  localparam logic [2:0] ST_CLEAR    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] corner;
  logic [1:0] corner_next;
  logic       sweep_result;
  logic       sweep_result_next;

  // State registers; reset starts with a clearing sweep that gives no result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      corner       <= 2'd0;
      sweep_result <= 1'b0;
    end else begin
      state        <= state_next;
      corner       <= corner_next;
      sweep_result <= sweep_result_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next        = state;
    corner_next       = corner;
    sweep_result_next = sweep_result;
    cmd               = '0;
    cmd.corner        = corner;
    in_ready          = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_next  = ST_DISPATCH;
          corner_next = 2'd0;
        end
      end
      ST_DISPATCH: begin
        if (sts.bad) begin
          state_next = ST_DONE;
        end else begin
          case (sts.kind)
            mvab_pkg::KIND_FACE,
            mvab_pkg::KIND_READ: state_next = ST_READ;
            mvab_pkg::KIND_CLEAR: begin
              state_next        = ST_CLEAR;
              sweep_result_next = 1'b1;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = (sts.kind == mvab_pkg::KIND_FACE) ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        cmd.wr_en = 1'b1;
        if (corner == 2'd2) begin
          state_next = ST_DONE;
        end else begin
          corner_next = corner + 2'd1;
          state_next  = ST_READ;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next        = sweep_result ? ST_DONE : ST_IDLE;
          sweep_result_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded into an occupied output register");

  // The memory is never written by a corner and by the sweep together.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.clr_en))
    else $error("corner write collides with clearing sweep");

  // A face walks at most three corners.
  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    corner != 2'd3)
    else $error("corner counter past the third corner");

  // A row write always follows its own row read.
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> $past(cmd.rd_en))
    else $error("row written without a preceding read");
`endif

endmodule
`default_nettype wire

// ===== hdl/mesh_vertex_adjacency_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_vertex_adjacency_builder
// Builds a per-vertex neighbor table from triangle faces and answers
// neighbor reads; top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Each request gives one result. An add-face request first checks its indices,
// then does a row read and a row write of the neighbor row memory for each of
// the three corners, then loads the result. A read checks its index, reads its
// row and loads the result, and a request with a rejected index or an unused
// kind goes from the index check straight to the load. The load waits while
// the output register still holds a result that has not been taken, and after
// the load the block returns to its idle state, where it accepts the next
// request. A clear request, and reset itself, sweeps every row of the memory
// one row per cycle (MAX_VERTICES rows, 4096 by default), and accepts no request
// meanwhile; configuration writes are taken at any time. A new request may be
// accepted while the previous result still waits in the output register.
module mesh_vertex_adjacency_builder #(
  parameter int MAX_VERTICES     = mvab_pkg::MAX_VERTICES_DEF,
  parameter int SLOTS_PER_VERTEX = mvab_pkg::SLOTS_PER_VERTEX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mvab_pkg::KIND_W-1:0]    kind,
  input  wire logic [mvab_pkg::VERTEX_W-1:0]  vertex_a,
  input  wire logic [mvab_pkg::VERTEX_W-1:0]  vertex_b,
  input  wire logic [mvab_pkg::VERTEX_W-1:0]  vertex_c,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [mvab_pkg::ENTRY_W-1:0] neighbor_0,
  output logic signed [mvab_pkg::ENTRY_W-1:0] neighbor_1,
  output logic signed [mvab_pkg::ENTRY_W-1:0] neighbor_2,
  output logic signed [mvab_pkg::ENTRY_W-1:0] neighbor_3,
  output logic signed [mvab_pkg::ENTRY_W-1:0] neighbor_4,
  output logic signed [mvab_pkg::ENTRY_W-1:0] neighbor_5,
  output logic                                overflow,
  output logic                                bad_index,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mvab_pkg::COUNT_W-1:0]   cfg_data
);

  mvab_pkg::cmd_t cmd;
  mvab_pkg::sts_t sts;

  // The vertex count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  mvab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  mvab_datapath #(
    .MAX_VERTICES     (MAX_VERTICES),
    .SLOTS_PER_VERTEX (SLOTS_PER_VERTEX)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .vertex_c   (vertex_c),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .neighbor_0 (neighbor_0),
    .neighbor_1 (neighbor_1),
    .neighbor_2 (neighbor_2),
    .neighbor_3 (neighbor_3),
    .neighbor_4 (neighbor_4),
    .neighbor_5 (neighbor_5),
    .overflow   (overflow),
    .bad_index  (bad_index)
  );

endmodule
`default_nettype wire
